FILE: hdl/svtrc_pkg.sv
// ----------------------------------------------------------------------------
// svtrc_pkg: shared types and constants of the sorted value table
// Entry layout, cell command, cell flags, controller states and codes.
// ----------------------------------------------------------------------------
package svtrc_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int NPOW     = 1 << IDX_W;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_W    = 11;
    localparam int ID_W     = 16;
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;
    localparam int ENC_LAT  = IDX_W;
    localparam int LAT_W    = $clog2(ENC_LAT + 1);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MISSING = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  house_id;
        logic [ID_W-1:0]  plug_id;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [ID_W-1:0]  house_id;
        logic [ID_W-1:0]  plug_id;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] old_value;
        logic [IDX_W-1:0] remove_at;
        logic [CNT_W-1:0] total;
    } cell_cmd_t;

    typedef struct packed {
        logic le;
        logic gt_edge;
        logic match;
    } cell_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_WAIT,
        ST_REMOVE,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/svtrc_cell.sv
// ----------------------------------------------------------------------------
// svtrc_cell: one slot of the sorted row
// Holds one entry, compares it against the broadcast key and shifts
// toward or away from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module svtrc_cell (
    input  logic                          aclk,
    input  logic [svtrc_pkg::IDX_W-1:0]   cell_index,
    input  svtrc_pkg::cell_cmd_t          cmd,
    input  svtrc_pkg::entry_t             left_entry,
    input  logic                          left_le,
    input  svtrc_pkg::entry_t             right_entry,
    output svtrc_pkg::entry_t             entry_q,
    output svtrc_pkg::cell_flags_t        flags
);

    svtrc_pkg::entry_t entry_reg;
    svtrc_pkg::entry_t entry_next;
    svtrc_pkg::entry_t new_entry;
    logic              valid;
    logic              le;

    assign valid = svtrc_pkg::CNT_W'(cell_index) < cmd.total;
    assign le    = valid && (entry_reg.value <= cmd.value);

    assign flags.le      = le;
    assign flags.gt_edge = !le && left_le;
    assign flags.match   = valid && (entry_reg.house_id == cmd.house_id)
                           && (entry_reg.plug_id == cmd.plug_id)
                           && (entry_reg.value == cmd.old_value);

    assign new_entry.house_id = cmd.house_id;
    assign new_entry.plug_id  = cmd.plug_id;
    assign new_entry.value    = cmd.value;

    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            svtrc_pkg::CELL_INSERT: begin
                if (le) begin
                    entry_next = entry_reg;
                end else if (left_le) begin
                    entry_next = new_entry;
                end else begin
                    entry_next = left_entry;
                end
            end
            svtrc_pkg::CELL_REMOVE: begin
                if (cell_index >= cmd.remove_at) begin
                    entry_next = right_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

FILE: hdl/svtrc_enc.sv
// ----------------------------------------------------------------------------
// svtrc_enc: pipelined priority encoder
// Registered binary tree; returns the lowest set request and its index.
// ----------------------------------------------------------------------------
module svtrc_enc (
    input  logic                          aclk,
    input  logic [svtrc_pkg::CAPACITY-1:0] req,
    output logic                          hit,
    output logic [svtrc_pkg::IDX_W-1:0]   index
);

    logic [svtrc_pkg::NPOW-1:0]  leaf;
    logic                        hit_reg [1:svtrc_pkg::NPOW-1];
    logic [svtrc_pkg::IDX_W-1:0] idx_reg [1:svtrc_pkg::NPOW-1];

    assign leaf = svtrc_pkg::NPOW'(req);

    for (genvar n = 1; n < svtrc_pkg::NPOW; n++) begin : g_node
        localparam int H = svtrc_pkg::IDX_W - ($clog2(n + 1) - 1);
        logic                        lh;
        logic                        rh;
        logic [svtrc_pkg::IDX_W-1:0] li;
        logic [svtrc_pkg::IDX_W-1:0] ri;

        if (2 * n >= svtrc_pkg::NPOW) begin : g_leaf
            assign lh = leaf[2 * n - svtrc_pkg::NPOW];
            assign rh = leaf[2 * n + 1 - svtrc_pkg::NPOW];
            assign li = '0;
            assign ri = '0;
        end else begin : g_inner
            assign lh = hit_reg[2 * n];
            assign rh = hit_reg[2 * n + 1];
            assign li = idx_reg[2 * n];
            assign ri = idx_reg[2 * n + 1];
        end

        always_ff @(posedge aclk) begin
            hit_reg[n] <= lh | rh;
            idx_reg[n] <= lh ? li : (ri | (svtrc_pkg::IDX_W'(1) << (H - 1)));
        end
    end

    assign hit   = hit_reg[1];
    assign index = idx_reg[1];

endmodule

FILE: hdl/sorted_value_table_rank_count_unit.sv
// ----------------------------------------------------------------------------
// sorted_value_table_rank_count_unit: sorted table with insert, update, count
// Row of CAPACITY cells kept sorted by value, with a pipelined encoder for
// rank and lookup.
// ----------------------------------------------------------------------------
// One item is taken at a time. An insert passes through the insert and finish
// states (straight to finish on a full table); a count waits in the wait state
// for the registered priority encoder tree of depth log2(CAPACITY), which
// locates the rank boundary or the matching entry, then finishes; an update
// found there goes on through remove and insert, and one that is missing
// finishes; mode 3 goes straight to finish. The shift is done in every cell at
// once. While an earlier result is still held by a stalled receiver, the item
// waits until that result is taken.
// A result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module sorted_value_table_rank_count_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [svtrc_pkg::MODE_W-1:0]        s_mode,
    input  logic [svtrc_pkg::ID_W-1:0]          s_house_id,
    input  logic [svtrc_pkg::ID_W-1:0]          s_plug_id,
    input  logic [svtrc_pkg::VAL_W-1:0]         s_value,
    input  logic [svtrc_pkg::VAL_W-1:0]         s_old_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [svtrc_pkg::OUT_W-1:0]         m_above_count,
    output logic [svtrc_pkg::STAT_W-1:0]        m_status,
    output logic [svtrc_pkg::OUT_W-1:0]         m_occupancy
);

    svtrc_pkg::state_t state_reg, state_next;

    logic [svtrc_pkg::CNT_W-1:0]  total_reg, total_next;
    logic [svtrc_pkg::LAT_W-1:0]  cnt_reg, cnt_next;
    logic [svtrc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [svtrc_pkg::ID_W-1:0]   house_reg, house_next;
    logic [svtrc_pkg::ID_W-1:0]   plug_reg, plug_next;
    logic [svtrc_pkg::VAL_W-1:0]  value_reg, value_next;
    logic [svtrc_pkg::VAL_W-1:0]  old_reg, old_next;
    logic [svtrc_pkg::IDX_W-1:0]  at_reg, at_next;
    logic [svtrc_pkg::STAT_W-1:0] status_reg, status_next;
    logic [svtrc_pkg::CNT_W-1:0]  above_reg, above_next;

    logic                         m_valid_reg, m_valid_next;
    logic [svtrc_pkg::OUT_W-1:0]  m_above_reg, m_above_next;
    logic [svtrc_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic [svtrc_pkg::OUT_W-1:0]  m_occ_reg, m_occ_next;

    svtrc_pkg::cell_cmd_t         cmd;
    svtrc_pkg::entry_t            cell_q   [svtrc_pkg::CAPACITY];
    svtrc_pkg::cell_flags_t       cell_fl  [svtrc_pkg::CAPACITY];
    logic [svtrc_pkg::CAPACITY-1:0] match_vec;
    logic [svtrc_pkg::CAPACITY-1:0] edge_vec;
    logic [svtrc_pkg::CAPACITY-1:0] enc_req;
    logic                         enc_hit;
    logic [svtrc_pkg::IDX_W-1:0]  enc_idx;
    logic [svtrc_pkg::CNT_W-1:0]  rank;
    logic                         full;
    logic                         enc_done;
    logic                         out_free;

    for (genvar i = 0; i < svtrc_pkg::CAPACITY; i++) begin : g_cell
        svtrc_pkg::entry_t left_entry;
        svtrc_pkg::entry_t right_entry;
        logic              left_le;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_le    = 1'b1;
        end else begin : g_left
            assign left_entry = cell_q[i - 1];
            assign left_le    = cell_fl[i - 1].le;
        end

        if (i == svtrc_pkg::CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_right
            assign right_entry = cell_q[i + 1];
        end

        svtrc_cell u_cell (
            .aclk        (aclk),
            .cell_index  (svtrc_pkg::IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry_q     (cell_q[i]),
            .flags       (cell_fl[i])
        );

        assign match_vec[i] = cell_fl[i].match;
        assign edge_vec[i]  = cell_fl[i].gt_edge;
    end

    assign enc_req = (mode_reg == svtrc_pkg::MODE_UPDATE) ? match_vec : edge_vec;

    svtrc_enc u_enc (
        .aclk  (aclk),
        .req   (enc_req),
        .hit   (enc_hit),
        .index (enc_idx)
    );

    assign rank     = enc_hit ? svtrc_pkg::CNT_W'(enc_idx)
                              : svtrc_pkg::CNT_W'(svtrc_pkg::CAPACITY);
    assign full     = total_reg == svtrc_pkg::CNT_W'(svtrc_pkg::CAPACITY);
    assign enc_done = cnt_reg == svtrc_pkg::LAT_W'(svtrc_pkg::ENC_LAT);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svtrc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    priority if (s_mode == svtrc_pkg::MODE_INSERT) begin
                        state_next = full ? svtrc_pkg::ST_FINISH : svtrc_pkg::ST_INSERT;
                    end else if (s_mode == svtrc_pkg::MODE_UPDATE ||
                                 s_mode == svtrc_pkg::MODE_COUNT) begin
                        state_next = svtrc_pkg::ST_WAIT;
                    end else begin
                        state_next = svtrc_pkg::ST_FINISH;
                    end
                end
            end
            svtrc_pkg::ST_INSERT: state_next = svtrc_pkg::ST_FINISH;
            svtrc_pkg::ST_WAIT: begin
                if (enc_done) begin
                    if (mode_reg == svtrc_pkg::MODE_UPDATE && enc_hit) begin
                        state_next = svtrc_pkg::ST_REMOVE;
                    end else begin
                        state_next = svtrc_pkg::ST_FINISH;
                    end
                end
            end
            svtrc_pkg::ST_REMOVE: state_next = svtrc_pkg::ST_INSERT;
            svtrc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = svtrc_pkg::ST_IDLE;
                end
            end
            default: state_next = svtrc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        total_next    = total_reg;
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        house_next    = house_reg;
        plug_next     = plug_reg;
        value_next    = value_reg;
        old_next      = old_reg;
        at_next       = at_reg;
        status_next   = status_reg;
        above_next    = above_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_above_next  = m_above_reg;
        m_status_next = m_status_reg;
        m_occ_next    = m_occ_reg;
        cmd.op        = svtrc_pkg::CELL_HOLD;
        cmd.house_id  = house_reg;
        cmd.plug_id   = plug_reg;
        cmd.value     = value_reg;
        cmd.old_value = old_reg;
        cmd.remove_at = at_reg;
        cmd.total     = total_reg;
        s_ready       = 1'b0;

        unique case (state_reg)
            svtrc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mode_next   = s_mode;
                    house_next  = s_house_id;
                    plug_next   = s_plug_id;
                    value_next  = s_value;
                    old_next    = s_old_value;
                    cnt_next    = '0;
                    above_next  = '0;
                    status_next = (s_mode == svtrc_pkg::MODE_INSERT && full)
                                  ? svtrc_pkg::STATUS_FULL : svtrc_pkg::STATUS_OK;
                end
            end
            svtrc_pkg::ST_INSERT: begin
                cmd.op     = svtrc_pkg::CELL_INSERT;
                total_next = total_reg + svtrc_pkg::CNT_W'(1);
            end
            svtrc_pkg::ST_WAIT: begin
                cnt_next = cnt_reg + svtrc_pkg::LAT_W'(1);
                if (enc_done) begin
                    if (mode_reg == svtrc_pkg::MODE_COUNT) begin
                        above_next = total_reg - rank;
                    end else if (enc_hit) begin
                        at_next = enc_idx;
                    end else begin
                        status_next = svtrc_pkg::STATUS_MISSING;
                    end
                end
            end
            svtrc_pkg::ST_REMOVE: begin
                cmd.op     = svtrc_pkg::CELL_REMOVE;
                total_next = total_reg - svtrc_pkg::CNT_W'(1);
            end
            svtrc_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_above_next  = svtrc_pkg::OUT_W'(above_reg);
                    m_status_next = status_reg;
                    m_occ_next    = svtrc_pkg::OUT_W'(total_reg);
                end
            end
            default: cmd.op = svtrc_pkg::CELL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= svtrc_pkg::ST_IDLE;
            total_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        house_reg    <= house_next;
        plug_reg     <= plug_next;
        value_reg    <= value_next;
        old_reg      <= old_next;
        at_reg       <= at_next;
        status_reg   <= status_next;
        above_reg    <= above_next;
        m_above_reg  <= m_above_next;
        m_status_reg <= m_status_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_above_count = m_above_reg;
    assign m_status      = m_status_reg;
    assign m_occupancy   = m_occ_reg;

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= svtrc_pkg::CNT_W'(svtrc_pkg::CAPACITY))
        else $error("entry total above capacity");

    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == svtrc_pkg::ST_INSERT |=>
            total_reg == $past(total_reg) + svtrc_pkg::CNT_W'(1))
        else $error("insert did not grow the table by one");

    a_remove_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == svtrc_pkg::ST_REMOVE |=>
            total_reg == $past(total_reg) - svtrc_pkg::CNT_W'(1) &&
            state_reg == svtrc_pkg::ST_INSERT)
        else $error("remove did not shrink the table and reinsert");

    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> m_occ_reg == svtrc_pkg::OUT_W'(total_reg))
        else $error("reported occupancy differs from entry total");

endmodule

FILE: tb/svtrc_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svtrc_table_checker: result checker for the sorted value table
// Watches both channels. Each input beat is run through a local sorted table
// to get the expected count, status and occupancy. Each result beat is then
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module svtrc_table_checker
    import svtrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [ID_W-1:0]    s_house_id,
    input  logic [ID_W-1:0]    s_plug_id,
    input  logic [VAL_W-1:0]   s_value,
    input  logic [VAL_W-1:0]   s_old_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [OUT_W-1:0]   m_above_count,
    input  logic [STAT_W-1:0]  m_status,
    input  logic [OUT_W-1:0]   m_occupancy,
    output int                 pending,
    output int                 fail_count
);

    typedef struct packed {
        logic [OUT_W-1:0]  above_count;
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  occupancy;
    } reply_t;

    entry_t held_rows[$];
    reply_t due_replies[$];

    task automatic flag_error(string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int rows_at_or_below(logic [VAL_W-1:0] limit);
        int k;
        k = 0;
        while (k < held_rows.size() && held_rows[k].value <= limit)
            k++;
        return k;
    endfunction

    function automatic reply_t table_reply(logic [MODE_W-1:0] mode, entry_t row,
                                           logic [VAL_W-1:0] old_value);
        reply_t r;
        int k;
        r = '0;
        case (mode)
            MODE_INSERT: begin
                if (held_rows.size() >= CAPACITY)
                    r.status = STATUS_FULL;
                else
                    held_rows.insert(rows_at_or_below(row.value), row);
            end
            MODE_UPDATE: begin
                k = 0;
                while (k < held_rows.size() &&
                       !(held_rows[k].house_id == row.house_id &&
                         held_rows[k].plug_id == row.plug_id &&
                         held_rows[k].value == old_value))
                    k++;
                if (k >= held_rows.size()) begin
                    r.status = STATUS_MISSING;
                end else begin
                    held_rows.delete(k);
                    held_rows.insert(rows_at_or_below(row.value), row);
                end
            end
            MODE_COUNT: begin
                r.above_count = OUT_W'(held_rows.size() - rows_at_or_below(row.value));
            end
            default: begin
            end
        endcase
        r.occupancy = OUT_W'(held_rows.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        entry_t beat_row;
        if (!aresetn) begin
            held_rows.delete();
            due_replies.delete();
            pending    <= 0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_replies.size() == 0) begin
                    flag_error($sformatf("result beat with nothing pending: %0d %0d %0d",
                                         m_above_count, m_status, m_occupancy));
                end else begin
                    want = due_replies.pop_front();
                    if (m_above_count !== want.above_count)
                        flag_error($sformatf("above_count got %0d want %0d",
                                             m_above_count, want.above_count));
                    if (m_status !== want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             m_status, want.status));
                    if (m_occupancy !== want.occupancy)
                        flag_error($sformatf("occupancy got %0d want %0d",
                                             m_occupancy, want.occupancy));
                end
            end
            if (s_valid && s_ready) begin
                beat_row.house_id = s_house_id;
                beat_row.plug_id  = s_plug_id;
                beat_row.value    = s_value;
                due_replies.push_back(table_reply(s_mode, beat_row, s_old_value));
            end
            pending <= due_replies.size();
        end
    end

endmodule

FILE: tb/tb_sorted_value_table_rank_count_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_value_table_rank_count_unit: regression for the sorted table
// Directed items first: empty table, extreme values, ties and duplicates,
// missing entries and the unused mode. Then random inserts, updates of live
// entries, near misses, counts and the unused mode. The sender runs in
// bursts and the receiver stalls on its own pattern; the checker instance
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_value_table_rank_count_unit;
    import svtrc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic [MODE_W-1:0]  s_mode      = '0;
    logic [ID_W-1:0]    s_house_id  = '0;
    logic [ID_W-1:0]    s_plug_id   = '0;
    logic [VAL_W-1:0]   s_value     = '0;
    logic [VAL_W-1:0]   s_old_value = '0;
    logic               m_ready     = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [OUT_W-1:0]   m_above_count;
    logic [STAT_W-1:0]  m_status;
    logic [OUT_W-1:0]   m_occupancy;
    int                 pending;
    int                 fail_count;

    entry_t live_rows[$];
    int     burst_left  = 0;
    int     rx_left     = 0;
    int     rx_style    = 0;

    always #1 aclk = ~aclk;

    sorted_value_table_rank_count_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_house_id    (s_house_id),
        .s_plug_id     (s_plug_id),
        .s_value       (s_value),
        .s_old_value   (s_old_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_above_count (m_above_count),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy)
    );

    svtrc_table_checker table_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_house_id    (s_house_id),
        .s_plug_id     (s_plug_id),
        .s_value       (s_value),
        .s_old_value   (s_old_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_above_count (m_above_count),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((rx_left % 5) < 2);
        endcase
    end

    function automatic logic [ID_W-1:0] rand_id();
        if ($urandom_range(0, 1) == 0)
            return ID_W'($urandom_range(0, 3));
        return ID_W'($urandom());
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return '0;
            1:       return '1;
            2:       return VAL_W'($urandom_range(0, 1)) ^ {VAL_W{1'b1}} ^ VAL_W'(1);
            3, 4, 5: return VAL_W'($urandom_range(0, 15) << 8);
            default: return VAL_W'($urandom());
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_threshold();
        logic [VAL_W-1:0] v;
        if (live_rows.size() > 0 && $urandom_range(0, 1) == 0) begin
            v = live_rows[$urandom_range(0, live_rows.size() - 1)].value;
            return v + VAL_W'($urandom_range(0, 2)) - VAL_W'(1);
        end
        return rand_value();
    endfunction

    // keep a multiset of live entries so updates can target real rows
    function automatic void note_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] house,
                                      logic [ID_W-1:0] plug, logic [VAL_W-1:0] v,
                                      logic [VAL_W-1:0] old_v);
        entry_t row;
        int k;
        row.house_id = house;
        row.plug_id  = plug;
        row.value    = v;
        if (mode == MODE_INSERT && live_rows.size() < CAPACITY) begin
            live_rows.push_back(row);
        end else if (mode == MODE_UPDATE) begin
            k = 0;
            while (k < live_rows.size() &&
                   !(live_rows[k].house_id == house && live_rows[k].plug_id == plug &&
                     live_rows[k].value == old_v))
                k++;
            if (k < live_rows.size())
                live_rows[k].value = v;
        end
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic send_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] house,
                             logic [ID_W-1:0] plug, logic [VAL_W-1:0] v,
                             logic [VAL_W-1:0] old_v);
        pace();
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_house_id  <= house;
        s_plug_id   <= plug;
        s_value     <= v;
        s_old_value <= old_v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        note_item(mode, house, plug, v, old_v);
    endtask

    task automatic drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_item();
        int pick;
        entry_t row;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_item(MODE_INSERT, rand_id(), rand_id(), rand_value(), VAL_W'($urandom()));
        end else if (pick < 70 && live_rows.size() > 0) begin
            row = live_rows[$urandom_range(0, live_rows.size() - 1)];
            send_item(MODE_UPDATE, row.house_id, row.plug_id, rand_value(), row.value);
        end else if (pick < 75 && live_rows.size() > 0) begin
            row = live_rows[$urandom_range(0, live_rows.size() - 1)];
            send_item(MODE_UPDATE, row.house_id, row.plug_id, rand_value(),
                      row.value + VAL_W'(1));
        end else if (pick < 82) begin
            send_item(MODE_UPDATE, rand_id(), rand_id(), rand_value(), rand_value());
        end else if (pick < 96) begin
            send_item(MODE_COUNT, rand_id(), rand_id(), rand_threshold(),
                      VAL_W'($urandom()));
        end else begin
            send_item(MODE_SPARE, ID_W'($urandom()), ID_W'($urandom()),
                      VAL_W'($urandom()), VAL_W'($urandom()));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_UPDATE, 16'h0000, 16'h0000, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_INSERT, 16'h0000, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(MODE_INSERT, 16'h0001, 16'h0002, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_INSERT, 16'h0001, 16'h0002, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_INSERT, 16'h0003, 16'h0004, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_COUNT,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'hFFFF_FFFE, 32'h0000_0000);
        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'h0000_00FF, 32'h0000_0000);
        send_item(MODE_UPDATE, 16'h0001, 16'h0002, 32'h0000_0080, 32'h0000_0100);
        send_item(MODE_UPDATE, 16'h0001, 16'h0002, 32'hFFFF_FFFF, 32'h0000_0100);
        send_item(MODE_UPDATE, 16'h0001, 16'h0002, 32'h0000_0000, 32'h0000_0101);
        send_item(MODE_UPDATE, 16'h0003, 16'h0005, 32'h0000_0000, 32'h0000_0100);
        send_item(MODE_UPDATE, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_UPDATE, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_SPARE,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_SPARE,  16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_COUNT,  16'h0000, 16'h0000, 32'h0000_007F, 32'h0000_0000);
        drain();

        for (int n = 0; n < 580; n++) begin
            random_item();
            if (n == 290)
                drain();
        end

        drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #600000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/svtrc_pkg.sv
hdl/svtrc_cell.sv
hdl/svtrc_enc.sv
hdl/sorted_value_table_rank_count_unit.sv
tb/svtrc_table_checker.sv
tb/tb_sorted_value_table_rank_count_unit.sv
